// ----- hdl/dqd_pkg.sv -----
// shared types and codes for the double-ended queue with dump
// no dependencies; imported by the top level
package dqd_pkg;

  // fixed payload widths
  localparam int VALUE_W  = 32;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;

  typedef logic [CMD_W-1:0]         cmd_t;
  typedef logic [STATUS_W-1:0]      status_t;
  typedef logic signed [VALUE_W-1:0] value_t;

  // command codes
  localparam cmd_t CMD_PUSH_FRONT = 3'd0;
  localparam cmd_t CMD_PUSH_BACK  = 3'd1;
  localparam cmd_t CMD_POP_FRONT  = 3'd2;
  localparam cmd_t CMD_POP_BACK   = 3'd3;
  localparam cmd_t CMD_DUMP_FWD   = 3'd4;
  localparam cmd_t CMD_DUMP_REV   = 3'd5;

  // status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

// ----- hdl/double_ended_queue_with_dump.sv -----
// top level of the double-ended queue with dump: command sequencer and state
// depends on dqd_pkg, dqd_ram and dqd_slot_unit
//
// Bounded double-ended queue of signed 32-bit values held in a ring ram of
// DEPTH slots. A command is taken when start_i is high and busy_o is low.
// Push and pop commands, and a dump of an empty queue, give one status beat;
// a dump of a non-empty queue gives one entry beat per stored entry, one per
// cycle, the last marked by last_of_run_o. Every ring address comes from a
// single shared modulo adder, and a dump is paced by the one read port of the
// ram.
// Result beats appear for exactly one cycle on strobe_o and cannot be held
// off; a new command may be started while a beat is on the outputs.
// Unused command codes give no beat.
module double_ended_queue_with_dump #(
  parameter int DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  dqd_pkg::cmd_t    cmd_i,
  input  dqd_pkg::value_t  item_value_i,
  output logic             strobe_o,
  output dqd_pkg::value_t  entry_value_o,
  output dqd_pkg::status_t status_o,
  output logic             is_entry_o,
  output logic             last_of_run_o
);

  import dqd_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP,
    S_DRAIN
  } state_e;

  // control state
  state_e           state_q, state_d;
  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic             fwd_q, fwd_d;
  logic             rd_pend_q, rd_pend_d;
  logic             rd_last_q, rd_last_d;
  logic             strobe_q, strobe_d;
  status_t          status_q, status_d;
  logic             is_entry_q, is_entry_d;
  logic             last_q, last_d;

  // payload
  cmd_t             cmd_q;
  value_t           value_q;
  value_t           entry_value_q, entry_value_d;
  logic [IDX_W-1:0] offset_q, offset_d;

  // ring access
  logic [IDX_W-1:0] slot_off;
  logic [IDX_W-1:0] slot;
  logic             wr_en;
  logic             rd_en;
  logic [VALUE_W-1:0] rd_data;
  logic             full;
  logic             empty;
  logic             accept;

  assign accept = start_i && (state_q == S_IDLE);
  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);

  // operand select for the shared index unit
  always_comb begin
    slot_off = IDX_W'(1);
    if (state_q == S_DUMP) begin
      slot_off = offset_q;
    end else begin
      case (cmd_q)
        CMD_PUSH_FRONT: slot_off = IDX_W'(DEPTH - 1);
        CMD_PUSH_BACK:  slot_off = count_q[IDX_W-1:0];
        default:        slot_off = IDX_W'(1);
      endcase
    end
  end

  dqd_slot_unit #(
    .DEPTH(DEPTH)
  ) u_slot (
    .base_i  (front_q),
    .offset_i(slot_off),
    .slot_o  (slot)
  );

  dqd_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(slot),
    .wr_data_i(value_q),
    .rd_en_i  (rd_en),
    .rd_addr_i(slot),
    .rd_data_o(rd_data)
  );

  // sequencer
  always_comb begin
    state_d       = state_q;
    front_d       = front_q;
    count_d       = count_q;
    rem_d         = rem_q;
    fwd_d         = fwd_q;
    offset_d      = offset_q;
    rd_pend_d     = 1'b0;
    rd_last_d     = rd_last_q;
    strobe_d      = 1'b0;
    status_d      = status_q;
    is_entry_d    = is_entry_q;
    last_d        = last_q;
    entry_value_d = entry_value_q;
    wr_en         = 1'b0;
    rd_en         = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d       = S_IDLE;
        strobe_d      = 1'b1;
        status_d      = ST_OK;
        is_entry_d    = 1'b0;
        last_d        = 1'b1;
        entry_value_d = '0;
        unique case (cmd_q) inside
          CMD_PUSH_FRONT: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              wr_en   = 1'b1;
              front_d = slot;
              count_d = count_q + CNT_W'(1);
            end
          end
          CMD_PUSH_BACK: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              wr_en   = 1'b1;
              count_d = count_q + CNT_W'(1);
            end
          end
          CMD_POP_FRONT: begin
            if (empty) begin
              status_d = ST_EMPTY;
            end else begin
              front_d = slot;
              count_d = count_q - CNT_W'(1);
            end
          end
          CMD_POP_BACK: begin
            if (empty) begin
              status_d = ST_EMPTY;
            end else begin
              count_d = count_q - CNT_W'(1);
            end
          end
          CMD_DUMP_FWD, CMD_DUMP_REV: begin
            if (empty) begin
              status_d = ST_EMPTY;
            end else begin
              strobe_d = 1'b0;
              state_d  = S_DUMP;
              rem_d    = count_q;
              fwd_d    = (cmd_q == CMD_DUMP_FWD);
              offset_d = (cmd_q == CMD_DUMP_FWD) ? '0
                                                 : IDX_W'(count_q - CNT_W'(1));
            end
          end
          default: begin
            // unused codes: no beat
            strobe_d = 1'b0;
          end
        endcase
      end
      S_DUMP: begin
        // one ram read per cycle, data lands next cycle
        rd_en     = 1'b1;
        rd_pend_d = 1'b1;
        rd_last_d = (rem_q == CNT_W'(1));
        rem_d     = rem_q - CNT_W'(1);
        offset_d  = fwd_q ? (offset_q + IDX_W'(1)) : (offset_q - IDX_W'(1));
        if (rem_q == CNT_W'(1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // entry beat from the read pipeline
    if (rd_pend_q) begin
      strobe_d      = 1'b1;
      status_d      = ST_OK;
      is_entry_d    = 1'b1;
      last_d        = rd_last_q;
      entry_value_d = value_t'(rd_data);
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      front_q       <= '0;
      count_q       <= '0;
      rem_q         <= '0;
      fwd_q         <= 1'b0;
      offset_q      <= '0;
      rd_pend_q     <= 1'b0;
      rd_last_q     <= 1'b0;
      strobe_q      <= 1'b0;
      status_q      <= ST_OK;
      is_entry_q    <= 1'b0;
      last_q        <= 1'b0;
      entry_value_q <= '0;
    end else begin
      state_q       <= state_d;
      front_q       <= front_d;
      count_q       <= count_d;
      rem_q         <= rem_d;
      fwd_q         <= fwd_d;
      offset_q      <= offset_d;
      rd_pend_q     <= rd_pend_d;
      rd_last_q     <= rd_last_d;
      strobe_q      <= strobe_d;
      status_q      <= status_d;
      is_entry_q    <= is_entry_d;
      last_q        <= last_d;
      entry_value_q <= entry_value_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      value_q <= item_value_i;
    end
  end

  assign busy_o        = (state_q != S_IDLE);
  assign strobe_o      = strobe_q;
  assign entry_value_o = entry_value_q;
  assign status_o      = status_q;
  assign is_entry_o    = is_entry_q;
  assign last_of_run_o = last_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("block not busy after a command was taken");

  a_status_beat_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !is_entry_o |-> last_of_run_o && entry_value_o == '0)
    else $error("status beat not marked last or carries data");

  a_dump_read_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DUMP |=> ##1 strobe_o && is_entry_o && status_o == ST_OK)
    else $error("dump read did not give an entry beat");

  a_entry_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && is_entry_o && !last_of_run_o |=> strobe_o && is_entry_o)
    else $error("dump run broken before its last beat");

endmodule

// ----- hdl/dqd_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module dqd_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hdl/dqd_slot_unit.sv -----
// shared ring index unit: slot = (base + offset) mod DEPTH
// no dependencies; used by the top-level sequencer for every ring access
module dqd_slot_unit #(
  parameter int DEPTH  = 16,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic [IDX_W-1:0] base_i,
  input  logic [IDX_W-1:0] offset_i,
  output logic [IDX_W-1:0] slot_o
);

  localparam logic [IDX_W:0] DepthW = (IDX_W + 1)'(DEPTH);

  logic [IDX_W:0] sum;
  logic [IDX_W:0] wrapped;

  // both operands below DEPTH, so one conditional subtract wraps the sum
  always_comb begin
    sum     = {1'b0, base_i} + {1'b0, offset_i};
    wrapped = (sum >= DepthW) ? (sum - DepthW) : sum;
    slot_o  = wrapped[IDX_W-1:0];
  end

endmodule
